// File: rtl/core/bvs_pkg.sv
`timescale 1ns / 1ps
package bvs_pkg;

  localparam int ANGLE_BITS      = 16;
  localparam int DEF_MAX_GAP_MS  = 2000;
  localparam int DEF_COMP_BITS   = 20;
  localparam logic [15:0] EASE_RESET = 16'd200;

  localparam int CORDIC_STEPS    = 24;
  localparam int SERIES_TERMS    = 13;
  localparam int EXP_K_MAX       = 32;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
  localparam logic [31:0] EXP_M1_Q30      = 32'd395007542;
  localparam logic [30:0] ONE_Q30         = 31'd1073741824;

  typedef struct packed {
    logic [15:0] heading_angle;
    logic [15:0] track_angle;
    logic        track_ok;
    logic [31:0] time_ms;
  } bvs_in_t;

  typedef struct packed {
    logic [15:0] smooth_heading;
    logic [15:0] smooth_track;
  } bvs_out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ALPHA,
    S_DIVK,
    S_DIVR,
    S_SMUL,
    S_NLD,
    S_DIVN,
    S_EXP,
    S_EMUL,
    S_AFIN,
    S_RINIT,
    S_ROT,
    S_RFIN,
    S_UMUL_E,
    S_UMUL_N,
    S_UWR,
    S_VINIT,
    S_VEC,
    S_VFIN,
    S_OUT
  } bvs_state_t;

  // arctan(2^-i) as a 32-bit binary angle
  function automatic logic [31:0] atan_ang(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10680862;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/core/bearing_vector_smoother.sv
`timescale 1ns / 1ps
// Alpha needs no division when dt is 0 or tau is 1 or less; else it takes 16+30
// divide steps, 13 series terms and up to EXP_K_MAX exp(-1) products. The heading,
// and the track when track_ok is set, then gets a rotation and an update, or a direct
// load when its vector is zero; each bearing is vectored back to an angle unless zero.
// A result not yet taken stalls; a new item is taken only in idle, after the last result is registered.
// Reset clears the vectors, the timestamp and sets the time constant to 200 ms.
module bearing_vector_smoother #(
  parameter int MAX_GAP_MS     = bvs_pkg::DEF_MAX_GAP_MS,
  parameter int COMPONENT_BITS = bvs_pkg::DEF_COMP_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bvs_pkg::bvs_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bvs_pkg::bvs_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data
);
  import bvs_pkg::*;

  localparam int CW = COMPONENT_BITS;
  localparam int RS = 32 - CW;
  localparam logic signed [35:0] RHALF = (RS == 0) ? 36'sd0 : 36'(64'd1 << (RS - 1));
  localparam logic signed [35:0] C_TOP = 36'sd1 <<< (CW - 1);
  localparam logic [4:0] CNT_K   = 5'd15;
  localparam logic [4:0] CNT_30  = 5'd29;
  localparam logic [4:0] CNT_ROT = 5'(CORDIC_STEPS - 1);
  localparam logic [3:0] N_LAST  = 4'(SERIES_TERMS);
  localparam logic signed [35:0] HALF_PI = 36'sd1073741824;
  localparam logic signed [35:0] PI_ANG  = 36'sd2147483648;

  function automatic logic signed [35:0] rnd_c(input logic signed [35:0] v);
    logic signed [35:0] m;
    m = -v;
    if (v >= 0) return (v + RHALF) >>> RS;
    return -((m + RHALF) >>> RS);
  endfunction

  function automatic logic signed [CW-1:0] sat_c(input logic signed [35:0] v);
    if (v > C_TOP - 36'sd1) return CW'(C_TOP - 36'sd1);
    if (v < -C_TOP) return CW'(-C_TOP);
    return CW'(v);
  endfunction

  function automatic logic signed [35:0] rnd16(input logic signed [65:0] v);
    logic signed [65:0] m;
    m = -v;
    if (v >= 0) return 36'((v + 66'sd32768) >>> 16);
    return 36'(-((m + 66'sd32768) >>> 16));
  endfunction

  bvs_state_t st_r, st_nxt;

  logic [15:0] tau_r, tau_nxt;
  logic [31:0] last_time_r, last_time_nxt;
  logic        started_r, started_nxt;
  logic signed [CW-1:0] he_r, he_nxt, hn_r, hn_nxt, tke_r, tke_nxt, tkn_r, tkn_nxt;
  logic signed [CW-1:0] tgt_e_r, tgt_e_nxt, tgt_n_r, tgt_n_nxt;
  logic [15:0] ang_h_r, ang_h_nxt, ang_t_r, ang_t_nxt;
  logic        tok_r, tok_nxt;
  logic [15:0] dt_r, dt_nxt;
  logic [16:0] alpha_r, alpha_nxt;
  logic [29:0] q_r, q_nxt;
  logic [15:0] rm_r, rm_nxt, dv_r, dv_nxt, k_r, k_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [29:0] r_r, r_nxt;
  logic [30:0] term_r, term_nxt, sum_r, sum_nxt, e_r, e_nxt;
  logic [3:0]  n_r, n_nxt;
  logic [5:0]  kc_r, kc_nxt;
  logic signed [65:0] p_r, p_nxt;
  logic signed [35:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic        neg_r, neg_nxt, sel_r, sel_nxt;
  logic [15:0] oh_r, oh_nxt, ot_r, ot_nxt;
  logic        out_valid_r, out_valid_nxt;
  bvs_out_t    out_data_r, out_data_nxt;

  // shared divider step
  logic [16:0] dt17;
  logic        dge;
  logic [15:0] drm;
  logic [29:0] dq;
  // shared multiplier operands
  logic signed [33:0] ma;
  logic signed [31:0] mb;
  // shared CORDIC step
  logic signed [35:0] shx, shy, atn, cx_s, cy_s, cz_s;
  logic        cpos;
  // helpers
  logic [31:0] diff;
  logic [15:0] dt_in;
  logic signed [CW-1:0] cur_e, cur_n;
  logic        cur_zero;
  logic signed [CW:0] dif_e, dif_n;
  logic signed [31:0] z32;
  logic signed [35:0] rz, xr, yr, xv, yv;
  logic signed [CW-1:0] te_s, tn_s, upd_e, upd_n;
  logic [31:0] a32;
  logic [31:0] e_rnd;

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    dt17 = {rm_r, q_r[29]};
    dge  = (dt17 >= {1'b0, dv_r});
    drm  = dge ? 16'(dt17 - {1'b0, dv_r}) : dt17[15:0];
    dq   = {q_r[28:0], dge};
  end

  always_comb begin
    shx  = cx_r >>> cnt_r;
    shy  = cy_r >>> cnt_r;
    atn  = 36'(atan_ang(cnt_r));
    cpos = (st_r == S_ROT) ? !cz_r[35] : (cy_r <= 36'sd0);
    if (cpos) begin
      cx_s = cx_r - shy;
      cy_s = cy_r + shx;
      cz_s = cz_r - atn;
    end else begin
      cx_s = cx_r + shy;
      cy_s = cy_r - shx;
      cz_s = cz_r + atn;
    end
  end

  always_comb begin
    cur_e    = sel_r ? tke_r : he_r;
    cur_n    = sel_r ? tkn_r : hn_r;
    cur_zero = (cur_e == '0) && (cur_n == '0);
    dif_e    = (CW+1)'(tgt_e_r) - (CW+1)'(cur_e);
    dif_n    = (CW+1)'(tgt_n_r) - (CW+1)'(cur_n);
    case (st_r)
      S_SMUL: begin
        ma = $signed({3'b0, term_r});
        mb = $signed({2'b0, r_r});
      end
      S_EXP: begin
        ma = $signed({3'b0, e_r});
        mb = $signed(EXP_M1_Q30);
      end
      S_UMUL_E: begin
        ma = 34'(dif_e);
        mb = $signed({15'b0, alpha_r});
      end
      S_UMUL_N: begin
        ma = 34'(dif_n);
        mb = $signed({15'b0, alpha_r});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    p_nxt = 66'(ma) * 66'(mb);
  end

  always_comb begin
    diff  = started_r ? (in_data.time_ms - last_time_r) : 32'd0;
    dt_in = (diff[31] || diff > 32'(MAX_GAP_MS)) ? 16'd0 : diff[15:0];
    z32   = $signed({(st_r == S_RINIT && sel_r) ? ang_t_r : ang_h_r, 16'b0});
    rz    = 36'(z32);
    xr    = neg_r ? -cx_r : cx_r;
    yr    = neg_r ? -cy_r : cy_r;
    tn_s  = sat_c(rnd_c(xr));
    te_s  = sat_c(rnd_c(yr));
    xv    = 36'(cur_n) <<< RS;
    yv    = 36'(cur_e) <<< RS;
    a32   = cz_r[31:0] + 32'(1 << (31 - ANGLE_BITS));
    upd_e = sat_c(36'(cur_e) + rnd16(p_r));
    upd_n = sat_c(36'(cur_n) + rnd16(p_r));
    e_rnd = 32'({1'b0, e_r} + 32'd8192);
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (in_valid) st_nxt = S_ALPHA;
      S_ALPHA: st_nxt = (dt_r == '0 || tau_r <= 16'd1) ? S_RINIT : S_DIVK;
      S_DIVK:  if (cnt_r == CNT_K) st_nxt = S_DIVR;
      S_DIVR:  if (cnt_r == CNT_30) st_nxt = S_SMUL;
      S_SMUL:  st_nxt = S_NLD;
      S_NLD:   st_nxt = S_DIVN;
      S_DIVN:  if (cnt_r == CNT_30) st_nxt = (n_r == N_LAST) ? S_EXP : S_SMUL;
      S_EXP:   st_nxt = (kc_r != '0 && e_r != '0) ? S_EMUL : S_AFIN;
      S_EMUL:  st_nxt = S_EXP;
      S_AFIN:  st_nxt = S_RINIT;
      S_RINIT: st_nxt = S_ROT;
      S_ROT:   if (cnt_r == CNT_ROT) st_nxt = S_RFIN;
      S_RFIN: begin
        if (!cur_zero) st_nxt = S_UMUL_E;
        else if (!sel_r && tok_r) st_nxt = S_RINIT;
        else st_nxt = S_VINIT;
      end
      S_UMUL_E: st_nxt = S_UMUL_N;
      S_UMUL_N: st_nxt = S_UWR;
      S_UWR:   st_nxt = (!sel_r && tok_r) ? S_RINIT : S_VINIT;
      S_VINIT: begin
        if (!cur_zero) st_nxt = S_VEC;
        else if (sel_r) st_nxt = S_OUT;
        else st_nxt = S_VINIT;
      end
      S_VEC:   if (cnt_r == CNT_ROT) st_nxt = S_VFIN;
      S_VFIN:  st_nxt = sel_r ? S_OUT : S_VINIT;
      S_OUT:   if (!out_valid_r || out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    tau_nxt       = cfg_valid ? cfg_data : tau_r;
    last_time_nxt = last_time_r;
    started_nxt   = started_r;
    he_nxt = he_r; hn_nxt = hn_r; tke_nxt = tke_r; tkn_nxt = tkn_r;
    tgt_e_nxt = tgt_e_r; tgt_n_nxt = tgt_n_r;
    ang_h_nxt = ang_h_r; ang_t_nxt = ang_t_r; tok_nxt = tok_r;
    dt_nxt = dt_r; alpha_nxt = alpha_r;
    q_nxt = q_r; rm_nxt = rm_r; dv_nxt = dv_r; k_nxt = k_r; cnt_nxt = cnt_r;
    r_nxt = r_r; term_nxt = term_r; sum_nxt = sum_r; e_nxt = e_r; n_nxt = n_r;
    kc_nxt = kc_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r; neg_nxt = neg_r; sel_nxt = sel_r;
    oh_nxt = oh_r; ot_nxt = ot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (st_r)
      S_IDLE: if (in_valid) begin
        started_nxt   = 1'b1;
        last_time_nxt = in_data.time_ms;
        dt_nxt        = dt_in;
        ang_h_nxt     = in_data.heading_angle;
        ang_t_nxt     = in_data.track_angle;
        tok_nxt       = in_data.track_ok;
        sel_nxt       = 1'b0;
      end
      S_ALPHA: begin
        alpha_nxt = (dt_r == '0) ? 17'd0 : 17'd65536;
        q_nxt     = {dt_r, 14'b0};
        rm_nxt    = '0;
        dv_nxt    = tau_r;
        cnt_nxt   = '0;
      end
      S_DIVK: begin
        rm_nxt  = drm;
        q_nxt   = dq;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == CNT_K) begin
          k_nxt   = dq[15:0];
          q_nxt   = '0;
          cnt_nxt = '0;
        end
      end
      S_DIVR: begin
        rm_nxt  = drm;
        q_nxt   = dq;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == CNT_30) begin
          r_nxt    = dq;
          term_nxt = ONE_Q30;
          sum_nxt  = ONE_Q30;
          n_nxt    = 4'd1;
        end
      end
      S_NLD: begin
        q_nxt   = p_r[59:30];
        rm_nxt  = '0;
        dv_nxt  = {12'b0, n_r};
        cnt_nxt = '0;
      end
      S_DIVN: begin
        rm_nxt  = drm;
        q_nxt   = dq;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == CNT_30) begin
          term_nxt = {1'b0, dq};
          sum_nxt  = n_r[0] ? (sum_r - {1'b0, dq}) : (sum_r + {1'b0, dq});
          n_nxt    = n_r + 4'd1;
          e_nxt    = sum_nxt;
          kc_nxt   = (k_r > 16'(EXP_K_MAX)) ? 6'(EXP_K_MAX) : k_r[5:0];
        end
      end
      S_EMUL: begin
        e_nxt  = 31'((p_r + 66'sd536870912) >>> 30);
        kc_nxt = kc_r - 6'd1;
      end
      S_AFIN: alpha_nxt = 17'd65536 - 17'(e_rnd >> 14);
      S_RINIT: begin
        cx_nxt  = $signed({4'b0, CORDIC_GAIN_Q30});
        cy_nxt  = '0;
        cnt_nxt = '0;
        neg_nxt = 1'b0;
        cz_nxt  = rz;
        if (rz > HALF_PI) begin
          cz_nxt  = rz - PI_ANG;
          neg_nxt = 1'b1;
        end else if (rz < -HALF_PI) begin
          cz_nxt  = rz + PI_ANG;
          neg_nxt = 1'b1;
        end
      end
      S_ROT, S_VEC: begin
        cx_nxt  = cx_s;
        cy_nxt  = cy_s;
        cz_nxt  = cz_s;
        cnt_nxt = cnt_r + 5'd1;
      end
      S_RFIN: begin
        tgt_e_nxt = te_s;
        tgt_n_nxt = tn_s;
        if (cur_zero) begin
          // take the target directly
          if (sel_r) begin
            tke_nxt = te_s;
            tkn_nxt = tn_s;
            sel_nxt = 1'b0;
          end else begin
            he_nxt  = te_s;
            hn_nxt  = tn_s;
            sel_nxt = tok_r;
          end
        end
      end
      S_UMUL_N: begin
        if (sel_r) tke_nxt = upd_e;
        else he_nxt = upd_e;
      end
      S_UWR: begin
        if (sel_r) begin
          tkn_nxt = upd_n;
          sel_nxt = 1'b0;
        end else begin
          hn_nxt  = upd_n;
          sel_nxt = tok_r;
        end
      end
      S_VINIT: begin
        cnt_nxt = '0;
        cx_nxt  = xv;
        cy_nxt  = yv;
        cz_nxt  = '0;
        if (xv < 0) begin
          cx_nxt = -xv;
          cy_nxt = -yv;
          cz_nxt = PI_ANG;
        end
        if (cur_zero) begin
          if (sel_r) ot_nxt = '0;
          else oh_nxt = '0;
          sel_nxt = 1'b1;
        end
      end
      S_VFIN: begin
        if (sel_r) ot_nxt = a32[31:16];
        else oh_nxt = a32[31:16];
        sel_nxt = 1'b1;
      end
      S_OUT: if (!out_valid_r || out_ready) begin
        out_valid_nxt = 1'b1;
        out_data_nxt.smooth_heading = oh_r;
        out_data_nxt.smooth_track   = ot_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      tau_r       <= EASE_RESET;
      last_time_r <= '0;
      started_r   <= 1'b0;
      he_r        <= '0;
      hn_r        <= '0;
      tke_r       <= '0;
      tkn_r       <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      tau_r       <= tau_nxt;
      last_time_r <= last_time_nxt;
      started_r   <= started_nxt;
      he_r        <= he_nxt;
      hn_r        <= hn_nxt;
      tke_r       <= tke_nxt;
      tkn_r       <= tkn_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_e_r    <= tgt_e_nxt;
    tgt_n_r    <= tgt_n_nxt;
    ang_h_r    <= ang_h_nxt;
    ang_t_r    <= ang_t_nxt;
    tok_r      <= tok_nxt;
    dt_r       <= dt_nxt;
    alpha_r    <= alpha_nxt;
    q_r        <= q_nxt;
    rm_r       <= rm_nxt;
    dv_r       <= dv_nxt;
    k_r        <= k_nxt;
    cnt_r      <= cnt_nxt;
    r_r        <= r_nxt;
    term_r     <= term_nxt;
    sum_r      <= sum_nxt;
    e_r        <= e_nxt;
    n_r        <= n_nxt;
    kc_r       <= kc_nxt;
    p_r        <= p_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    cz_r       <= cz_nxt;
    neg_r      <= neg_nxt;
    oh_r       <= oh_nxt;
    ot_r       <= ot_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: verif/bearing_vector_smoother_test.sv
`timescale 1ns / 1ps
module bearing_vector_smoother_test;
  import bvs_pkg::*;

  localparam int  COMP_W    = 20;
  localparam int  GAP_MAX   = 2000;
  localparam int  CYCLE_CAP = 3000000;

  typedef struct {
    bvs_in_t  item;
    bit       known;
    bvs_out_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  bvs_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  bvs_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  bvs_out_t  bearing_q[$];
  stim_row_t dir_tab[$];
  int        errors = 0;
  int        cycles = 0;
  int        tx_idle = 0;
  int        rx_idle = 0;

  // predictor state
  longint      hd_e, hd_n, tk_e, tk_n;
  logic [31:0] prev_t;
  bit          begun;
  logic [15:0] tau;

  longint atan_q[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  bearing_vector_smoother uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint round_off(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -(((-v) + half) >>> s);
  endfunction

  function automatic longint clamp_comp(longint v);
    longint hi, lo;
    hi = (longint'(1) << (COMP_W - 1)) - 1;
    lo = -(longint'(1) << (COMP_W - 1));
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  task automatic unit_vec(input logic [15:0] ang, output longint e, output longint n);
    longint z, x, y, nx;
    bit     flip;
    z = longint'({32'h0, ang, 16'h0});
    x = 652032874;
    y = 0;
    flip = 0;
    if (z >= (longint'(1) << 31)) z -= longint'(1) << 32;
    if (z > (longint'(1) << 30)) begin
      z -= longint'(1) << 31;
      flip = 1;
    end else if (z < -(longint'(1) << 30)) begin
      z += longint'(1) << 31;
      flip = 1;
    end
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_q[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_q[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    e = clamp_comp(round_off(y, 32 - COMP_W));
    n = clamp_comp(round_off(x, 32 - COMP_W));
  endtask

  function automatic logic [15:0] vec_bearing(longint e, longint n);
    longint      x, y, z, nx;
    logic [31:0] a32;
    if (e == 0 && n == 0) return 16'h0;
    x = n * (longint'(1) << (32 - COMP_W));
    y = e * (longint'(1) << (32 - COMP_W));
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = longint'(1) << 31;
    end
    for (int i = 0; i < 24; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_q[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_q[i];
      end
      x = nx;
    end
    a32 = z[31:0] + 32'h8000;
    return a32[31:16];
  endfunction

  function automatic longint ease_factor(logic [31:0] dt, logic [15:0] tc);
    longint unsigned k, r, term, sum, e;
    if (dt == 0) return 0;
    if (tc <= 1) return 65536;
    k = dt / tc;
    r = (longint'(dt % tc) << 30) / tc;
    sum = 64'd1073741824;
    term = 64'd1073741824;
    for (int n = 1; n <= 13; n++) begin
      term = ((term * r) >> 30) / n;
      if (n % 2) sum -= term;
      else sum += term;
    end
    e = sum;
    if (k > 32) k = 32;
    while (k > 0 && e > 0) begin
      e = (e * 64'd395007542 + 64'd536870912) >> 30;
      k--;
    end
    return 65536 - longint'((e + 8192) >> 14);
  endfunction

  task automatic ease_toward(inout longint e, inout longint n, input logic [15:0] ang,
                             input longint a);
    longint te, tn;
    unit_vec(ang, te, tn);
    if (e == 0 && n == 0) begin
      e = te;
      n = tn;
    end else begin
      e = clamp_comp(e + round_off((te - e) * a, 16));
      n = clamp_comp(n + round_off((tn - n) * a, 16));
    end
  endtask

  task automatic smooth_item(input bvs_in_t d, output bvs_out_t r);
    logic [31:0] diff, dt;
    longint      a;
    if (!begun) begin
      begun = 1;
      prev_t = d.time_ms;
    end
    diff = d.time_ms - prev_t;
    dt = (diff[31] || diff > GAP_MAX) ? 32'd0 : diff;
    prev_t = d.time_ms;
    a = ease_factor(dt, tau);
    ease_toward(hd_e, hd_n, d.heading_angle, a);
    if (d.track_ok) ease_toward(tk_e, tk_n, d.track_angle, a);
    r.smooth_heading = vec_bearing(hd_e, hd_n);
    r.smooth_track = vec_bearing(tk_e, tk_n);
  endtask

  // hold valid across back-to-back items; drop it only to idle
  task automatic send_item(input bvs_in_t d, input bit known, input bvs_out_t want);
    bvs_out_t r;
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < tx_idle) @(negedge clk);
    end
    in_data <= d;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    smooth_item(d, r);
    bearing_q.push_back(known ? want : r);
    @(negedge clk);
  endtask

  task automatic write_tau(input logic [15:0] v);
    in_valid <= 1'b0;
    @(negedge clk);
    while (bearing_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    tau = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic bvs_in_t mk(logic [15:0] h, logic [15:0] t, logic ok, logic [31:0] tm);
    bvs_in_t d;
    d.heading_angle = h;
    d.track_angle = t;
    d.track_ok = ok;
    d.time_ms = tm;
    return d;
  endfunction

  function automatic stim_row_t row(bvs_in_t d, bit known = 0, logic [15:0] wh = 0,
                                    logic [15:0] wt = 0);
    stim_row_t s;
    s.item = d;
    s.known = known;
    s.want.smooth_heading = wh;
    s.want.smooth_track = wt;
    return s;
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk) begin
    bvs_out_t w;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (bearing_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item heading %h track %h", $time,
                 out_data.smooth_heading, out_data.smooth_track);
      end else begin
        w = bearing_q.pop_front();
        if (w.smooth_heading !== out_data.smooth_heading) begin
          errors++;
          $display("%0t: smooth_heading expected %h actual %h", $time,
                   w.smooth_heading, out_data.smooth_heading);
        end
        if (w.smooth_track !== out_data.smooth_track) begin
          errors++;
          $display("%0t: smooth_track expected %h actual %h", $time,
                   w.smooth_track, out_data.smooth_track);
        end
      end
    end
  end

  initial begin
    logic [15:0] taus[6] = '{16'd0, 16'd65535, 16'd1, 16'd50, 16'd2, 16'd200};
    logic [31:0] t;
    int          pick;
    bvs_out_t    none;
    hd_e = 0; hd_n = 0; tk_e = 0; tk_n = 0;
    prev_t = 0;
    begun = 0;
    tau = EASE_RESET;
    none = '0;

    // first sample straight after reset reads back as north with no track
    dir_tab.push_back(row(mk(16'h0000, 16'hFFFF, 1'b0, 32'd100), 1, 16'h0000, 16'h0000));
    dir_tab.push_back(row(mk(16'hFFFF, 16'h0000, 1'b1, 32'd100)));
    dir_tab.push_back(row(mk(16'h8000, 16'hFFFF, 1'b1, 32'd150)));
    dir_tab.push_back(row(mk(16'h4000, 16'h8000, 1'b1, 32'd149)));
    dir_tab.push_back(row(mk(16'hC000, 16'h4000, 1'b0, 32'd2149)));
    dir_tab.push_back(row(mk(16'h7FFF, 16'hC000, 1'b1, 32'd4150)));
    dir_tab.push_back(row(mk(16'h8001, 16'h7FFF, 1'b1, 32'd4151)));
    dir_tab.push_back(row(mk(16'h0001, 16'h0001, 1'b1, 32'hFFFF_FFF0)));
    dir_tab.push_back(row(mk(16'h2000, 16'hE000, 1'b1, 32'h0000_0010)));
    dir_tab.push_back(row(mk(16'hA000, 16'h6000, 1'b0, 32'h0000_0400)));
    dir_tab.push_back(row(mk(16'h5555, 16'hAAAA, 1'b1, 32'h8000_0400)));
    dir_tab.push_back(row(mk(16'hAAAA, 16'h5555, 1'b1, 32'h8000_0500)));
    dir_tab.push_back(row(mk(16'h0000, 16'h8000, 1'b1, 32'h8000_0C00)));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tx_idle = 27;
    rx_idle = 72;
    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].known, dir_tab[i].want);

    for (int p = 0; p < 6; p++) begin
      write_tau(p == 3 ? 16'($urandom) : taus[p]);
      tx_idle = (p < 2) ? 27 : (p < 4) ? 72 : 0;
      rx_idle = (p < 2) ? 72 : (p < 4) ? 27 : 0;
      t = prev_t;
      repeat (65) begin
        pick = $urandom_range(99);
        if (pick < 70) t += $urandom_range(1, 120);
        else if (pick < 86) t -= $urandom_range(1, 500);
        else if (pick < 93) t += $urandom_range(2001, 100000);
        else if (pick < 97) t = $urandom;
        send_item(mk(16'($urandom), 16'($urandom), 1'($urandom), t), 0, none);
      end
    end

    in_valid <= 1'b0;
    while (bearing_q.size() != 0) @(negedge clk);
    repeat (1200) @(negedge clk);
    if (errors == 0 && bearing_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
